@@ rtl/bucket_sort_integers_defines.svh @@
// Assertion macros used by the checker file of bucket_sort_integers.
// No dependencies.
`ifndef BUCKET_SORT_INTEGERS_DEFINES_SVH
`define BUCKET_SORT_INTEGERS_DEFINES_SVH

// same-cycle implication
`define BSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bsi_pkg.sv @@
// Package for bucket_sort_integers: sizes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package bsi_pkg;

   localparam int MAX_ITEMS    = 64;
   localparam int BUCKETS      = 256;
   localparam int VALUE_BITS   = 16;
   localparam int BKT_CNT_BITS = 7;

   localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int ELEM_AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int BKT_AW    = $clog2(BUCKETS);
   localparam int DIFF_BITS = VALUE_BITS + 1;

   localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLEAR,
      ST_CNT_RD,
      ST_CNT_ADDR,
      ST_CNT_INC,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic set_span;
      logic clr_bkt;
      logic bkt_inc;
      logic sel_elem_addr;
      logic bidx_clr;
      logic bidx_inc;
      logic idx_clr;
      logic idx_inc;
      logic rem_load;
      logic rem_dec;
      logic emit_val;
      logic emit_err;
      logic new_set;
   } cmd_type;

   typedef struct packed {
      logic range_bad;
      logic bidx_last;
      logic idx_last;
      logic bkt_zero;
      logic rem_one;
   } status_type;

endpackage

@@ rtl/bsi_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bsi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bsi_ctrl.sv @@
// Controller FSM for bucket_sort_integers: sequences load, range check,
// bucket clear, counting and the bucket walk. Depends on bsi_pkg.
module bsi_ctrl
   import bsi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       final_item,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && final_item) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.range_bad ? ST_IDLE : ST_CLEAR;
         end
         ST_CLEAR: begin
            if (status.bidx_last) state_in = ST_CNT_RD;
         end
         ST_CNT_RD:   state_in = ST_CNT_ADDR;
         ST_CNT_ADDR: state_in = ST_CNT_INC;
         ST_CNT_INC: begin
            state_in = status.idx_last ? ST_WALK_RD : ST_CNT_RD;
         end
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            state_in = status.bkt_zero ? ST_WALK_RD : ST_EMIT;
         end
         ST_EMIT: begin
            priority if (status.idx_last) state_in = ST_IDLE;
            else if (status.rem_one)      state_in = ST_WALK_RD;
            else                          state_in = ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CHECK: begin
            if (status.range_bad) begin
               cmd.emit_err = 1'b1;
               cmd.new_set  = 1'b1;
            end else begin
               cmd.set_span = 1'b1;
               cmd.bidx_clr = 1'b1;
            end
         end
         ST_CLEAR: begin
            cmd.clr_bkt = 1'b1;
            if (status.bidx_last) begin
               cmd.bidx_clr = 1'b1;
               cmd.idx_clr  = 1'b1;
            end else begin
               cmd.bidx_inc = 1'b1;
            end
         end
         ST_CNT_RD: begin
         end
         ST_CNT_ADDR: begin
            cmd.sel_elem_addr = 1'b1;
         end
         ST_CNT_INC: begin
            cmd.bkt_inc = 1'b1;
            if (status.idx_last) begin
               cmd.idx_clr  = 1'b1;
               cmd.bidx_clr = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_WALK_RD: begin
         end
         ST_WALK_CHK: begin
            if (status.bkt_zero) begin
               cmd.bidx_inc = 1'b1;
            end else begin
               cmd.rem_load = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit_val = 1'b1;
            if (status.idx_last) begin
               cmd.new_set = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
               if (status.rem_one) begin
                  cmd.bidx_inc = 1'b1;
               end else begin
                  cmd.rem_dec = 1'b1;
               end
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/bsi_dp.sv @@
// Datapath for bucket_sort_integers: element store, bucket counts, min/max,
// counters and the result register. Depends on bsi_pkg and bsi_ram.
module bsi_dp
   import bsi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output status_type                   status,
   output logic                         rsp_strobe,
   output logic signed [VALUE_BITS-1:0] rsp_sorted_value,
   output logic                         rsp_last_of_run,
   output logic                         rsp_range_error
);

   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic signed [VALUE_BITS-1:0] max_ff, max_in;
   logic [CNT_BITS-1:0]          idx_ff, idx_in;
   logic [BKT_AW-1:0]            bidx_ff, bidx_in;
   logic [BKT_AW-1:0]            span_ff, span_in;
   logic [BKT_AW-1:0]            bkt_addr_ff, bkt_addr_in;
   logic [BKT_CNT_BITS-1:0]      rem_ff, rem_in;

   logic                         strobe_ff, strobe_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic                         last_ff, last_in;
   logic                         err_ff, err_in;

   logic                         room;
   logic                         elem_we;
   logic [VALUE_BITS-1:0]        elem_rdata;
   logic [DIFF_BITS-1:0]         diff;
   logic [DIFF_BITS-1:0]         elem_off;
   logic [BKT_AW-1:0]            elem_bkt;
   logic                         bkt_we;
   logic [BKT_AW-1:0]            bkt_waddr;
   logic [BKT_CNT_BITS-1:0]      bkt_wdata;
   logic [BKT_AW-1:0]            bkt_raddr;
   logic [BKT_CNT_BITS-1:0]      bkt_rdata;

   assign room    = (count_ff < CNT_BITS'(MAX_ITEMS));
   assign elem_we = cmd.load && room;

   bsi_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (count_ff[ELEM_AW-1:0]),
      .wdata (req_value),
      .raddr (idx_ff[ELEM_AW-1:0]),
      .rdata (elem_rdata)
   );

   assign diff     = {max_ff[VALUE_BITS-1], max_ff} - {min_ff[VALUE_BITS-1], min_ff};
   assign elem_off = {elem_rdata[VALUE_BITS-1], elem_rdata} - {min_ff[VALUE_BITS-1], min_ff};
   assign elem_bkt = BKT_AW'(elem_off);

   assign bkt_we    = cmd.clr_bkt || cmd.bkt_inc;
   assign bkt_waddr = cmd.clr_bkt ? bidx_ff : bkt_addr_ff;
   assign bkt_wdata = cmd.clr_bkt ? '0 : BKT_CNT_BITS'(bkt_rdata + 1'b1);
   assign bkt_raddr = cmd.sel_elem_addr ? elem_bkt : bidx_ff;

   bsi_ram #(.WIDTH(BKT_CNT_BITS), .DEPTH(BUCKETS)) u_bkt_ram (
      .clock (clock),
      .we    (bkt_we),
      .waddr (bkt_waddr),
      .wdata (bkt_wdata),
      .raddr (bkt_raddr),
      .rdata (bkt_rdata)
   );

   always_comb begin
      count_in    = count_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      idx_in      = idx_ff;
      bidx_in     = bidx_ff;
      span_in     = span_ff;
      bkt_addr_in = cmd.sel_elem_addr ? elem_bkt : bkt_addr_ff;
      rem_in      = rem_ff;
      strobe_in   = cmd.emit_val || cmd.emit_err;
      value_in    = value_ff;
      last_in     = last_ff;
      err_in      = err_ff;

      if (elem_we) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
         if (req_value < min_ff) min_in = req_value;
         if (req_value > max_ff) max_in = req_value;
      end
      if (cmd.new_set) begin
         count_in = '0;
         min_in   = VMAX;
         max_in   = VMIN;
      end
      if (cmd.set_span) span_in = BKT_AW'(diff);

      priority if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc)     idx_in = CNT_BITS'(idx_ff + 1'b1);

      priority if (cmd.bidx_clr) bidx_in = '0;
      else if (cmd.bidx_inc)     bidx_in = BKT_AW'(bidx_ff + 1'b1);

      priority if (cmd.rem_load) rem_in = bkt_rdata;
      else if (cmd.rem_dec)      rem_in = BKT_CNT_BITS'(rem_ff - 1'b1);

      if (cmd.emit_val) begin
         value_in = $signed(VALUE_BITS'($unsigned(min_ff) + VALUE_BITS'(bidx_ff)));
         last_in  = status.idx_last;
         err_in   = 1'b0;
      end
      if (cmd.emit_err) begin
         value_in = '0;
         last_in  = 1'b1;
         err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= VMAX;
         max_ff    <= VMIN;
         idx_ff    <= '0;
         bidx_ff   <= '0;
         strobe_ff <= 1'b0;
         value_ff  <= '0;
         last_ff   <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         idx_ff    <= idx_in;
         bidx_ff   <= bidx_in;
         strobe_ff <= strobe_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      bkt_addr_ff <= bkt_addr_in;
      rem_ff      <= rem_in;
   end

   assign status.range_bad = (64'(diff) > 64'(BUCKETS - 1));
   assign status.bidx_last = (bidx_ff == span_ff);
   assign status.idx_last  = (CNT_BITS'(idx_ff + 1'b1) == count_ff);
   assign status.bkt_zero  = (bkt_rdata == '0);
   assign status.rem_one   = (rem_ff == BKT_CNT_BITS'(1));

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_range_error  = err_ff;

endmodule

@@ rtl/bucket_sort_integers.sv @@
// Top level of bucket_sort_integers: counting sort of a set of signed values.
// Depends on bsi_pkg, bsi_ctrl and bsi_dp.
//
// Usage:
//   Input: drive req_value and req_final_item with start high; the item is
//   taken at a clock edge where start is high and busy is low. Sets hold up
//   to 64 values; further values of the same set are dropped.
//   Loading takes one item per cycle while busy is low. The item with req_final_item set starts
//   the sort and busy rises until the last result has been issued.
//   Sort steps after the final item: a range check, a clear of span buckets
//   (span = max - min + 1, at most 256), a read, address and increment of
//   the bucket count per held value, then a walk that reads and checks each
//   visited bucket and emits one result per value that it holds.
//   Output: each result sits on the rsp_ ports for one cycle with rsp_strobe
//   high; rsp_last_of_run marks the final one. If the span exceeds 256 one
//   result with rsp_range_error and rsp_last_of_run follows the range check in
//   ST_CHECK, value zero. The receiver cannot stall: every strobe is a
//   transfer.
//   Reset: synchronous; clears the controller, the set state and the strobe.
module bucket_sort_integers
   import bsi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_final_item,
   output logic                         rsp_strobe,
   output logic signed [VALUE_BITS-1:0] rsp_sorted_value,
   output logic                         rsp_last_of_run,
   output logic                         rsp_range_error
);

   cmd_type    cmd;
   status_type status;

   bsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_item (req_final_item),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   bsi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

@@ rtl/bsi_checker.sv @@
// Port-level checker for bucket_sort_integers, bound to the top level.
// Depends on bsi_pkg and bucket_sort_integers_defines.svh.
`include "bucket_sort_integers_defines.svh"

module bsi_checker
   import bsi_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic signed [VALUE_BITS-1:0] req_value,
   input logic                         req_final_item,
   input logic                         rsp_strobe,
   input logic signed [VALUE_BITS-1:0] rsp_sorted_value,
   input logic                         rsp_last_of_run,
   input logic                         rsp_range_error
);

   `BSI_ASSERT_NOW(a_err_form, clock, reset, rsp_strobe && rsp_range_error, rsp_last_of_run && (rsp_sorted_value == '0), "error result malformed")

   `BSI_ASSERT_NOW(a_mid_busy, clock, reset, rsp_strobe && !rsp_last_of_run, busy, "non-final result while idle")

   `BSI_ASSERT_NEXT(a_load_quiet, clock, reset, start && !busy && !req_final_item, !rsp_strobe && !busy, "result or busy after a non-final transfer")

   `BSI_ASSERT_NEXT(a_err_single, clock, reset, rsp_strobe && rsp_range_error, !rsp_strobe, "error result followed by another")

endmodule

bind bucket_sort_integers bsi_checker u_bsi_checker (.*);
